### design/oriented_box_overlap_test_defines.svh
// Assertion macros for the oriented box overlap test.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ORIENTED_BOX_OVERLAP_TEST_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_DEFINES_SVH
`ifndef SYNTH
`define OBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OBT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OBT_ASSERT(label, prop, msg)
`define OBT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### design/obt_pkg.sv
// Shared widths, types and helpers for the oriented box overlap test.
// No dependencies.
`default_nettype none

package obt_pkg;

  localparam int COORD_BITS      = 24;
  localparam int AXIS_FRAC_BITS  = 14;
  localparam int AXIS_FIELD_BITS = 16;

  localparam int SZW  = COORD_BITS - 1;          // box width / height
  localparam int DW   = COORD_BITS + 1;          // center difference
  localparam int PPW  = DW + AXIS_FIELD_BITS;    // projection partial product
  localparam int PSW  = PPW + 1;                 // projection sum
  localparam int PMW  = PSW - 1;                 // projection magnitude
  localparam int RPW  = 2 * AXIS_FIELD_BITS;     // axis-axis product
  localparam int RSW  = RPW + 1;                 // axis-axis sum
  localparam int RMW  = RSW - 1;                 // axis-axis magnitude
  localparam int OPW  = SZW + RMW;               // extent partial product
  localparam int OSW  = OPW + 1;                 // other-box extent sum
  localparam int OWNW = SZW + 2 * AXIS_FRAC_BITS;
  localparam int LHW  = PMW + AXIS_FRAC_BITS + 1;
  localparam int RHW  = OSW + 1;
  localparam int NAX  = 4;

  localparam int BOX_BITS   = 4 * COORD_BITS + 2 * AXIS_FIELD_BITS - 2;
  localparam int IN_BITS    = 2 * BOX_BITS;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [2:0] {
    AXIS_A_RIGHT = 3'd0,
    AXIS_A_UP    = 3'd1,
    AXIS_B_RIGHT = 3'd2,
    AXIS_B_UP    = 3'd3,
    AXIS_NONE    = 3'd4
  } axis_t;

  // lowest bits first: cx, cy, rx, ry, w, h
  typedef struct packed {
    logic [SZW-1:0]                    h;
    logic [SZW-1:0]                    w;
    logic signed [AXIS_FIELD_BITS-1:0] ry;
    logic signed [AXIS_FIELD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0]      cy;
    logic signed [COORD_BITS-1:0]      cx;
  } box_t;

  typedef struct packed {
    logic  overlap;
    axis_t axis;
  } result_t;

  function automatic logic [PMW-1:0] mag_proj(input logic signed [PSW-1:0] v);
    logic [PSW-1:0] n;
    n = v[PSW-1] ? (~v + 1'b1) : v;
    return n[PMW-1:0];
  endfunction

  function automatic logic [RMW-1:0] mag_rot(input logic signed [RSW-1:0] v);
    logic [RSW-1:0] n;
    n = v[RSW-1] ? (~v + 1'b1) : v;
    return n[RMW-1:0];
  endfunction

endpackage

`default_nettype wire

### design/obt_sep_check.sv
// Final compare of the four axis tests and first-separating-axis select.
// Depends on obt_pkg.
`default_nettype none

module obt_sep_check (
  input  logic [obt_pkg::NAX-1:0][obt_pkg::LHW-1:0]  lhs,
  input  logic [obt_pkg::NAX-1:0][obt_pkg::OSW-1:0]  other,
  input  logic [obt_pkg::NAX-1:0][obt_pkg::SZW-1:0]  own,
  output obt_pkg::result_t                            res
);

  logic [obt_pkg::NAX-1:0][obt_pkg::RHW-1:0] rhs;
  logic [obt_pkg::NAX-1:0]                   sep;

  always_comb begin
    for (int i = 0; i < obt_pkg::NAX; i++) begin
      // own half extent already scaled by the folded 0.5
      rhs[i] = obt_pkg::RHW'(other[i])
             + (obt_pkg::RHW'(own[i]) << (2 * obt_pkg::AXIS_FRAC_BITS));
      sep[i] = obt_pkg::RHW'(lhs[i]) > rhs[i];
    end
  end

  always_comb begin
    res.overlap = 1'b0;
    priority if (sep[0]) begin
      res.axis = obt_pkg::AXIS_A_RIGHT;
    end else if (sep[1]) begin
      res.axis = obt_pkg::AXIS_A_UP;
    end else if (sep[2]) begin
      res.axis = obt_pkg::AXIS_B_RIGHT;
    end else if (sep[3]) begin
      res.axis = obt_pkg::AXIS_B_UP;
    end else begin
      res.axis    = obt_pkg::AXIS_NONE;
      res.overlap = 1'b1;
    end
  end

endmodule

`default_nettype wire

### design/oriented_box_overlap_test.sv
// Oriented box overlap test, top level: five-stage pipeline.
// Throughput: 1 beat per cycle while the output is not stalled by out_tready.
// Each stage holds its beat only while the stage after it is full and stalled.
// Reset (rst_n low, synchronous) empties every stage; payload registers keep data.
// Depends on obt_pkg, obt_sep_check and oriented_box_overlap_test_defines.svh.
`default_nettype none
`include "oriented_box_overlap_test_defines.svh"

module oriented_box_overlap_test (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // a_center_x, a_center_y, a_right_x, a_right_y, a_width, a_height,
  // b_center_x, b_center_y, b_right_x, b_right_y, b_width, b_height, zero pad
  input  logic [obt_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // overlap, separating_axis[2:0], zero pad
  output logic [obt_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  obt_pkg::box_t box_a, box_b;
  assign box_a = in_tdata[obt_pkg::BOX_BITS-1:0];
  assign box_b = in_tdata[2*obt_pkg::BOX_BITS-1:obt_pkg::BOX_BITS];

  // stage enables, back to front
  logic en1, en2, en3, en4, en_o;
  logic v1_r, v2_r, v3_r, v4_r, ov_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, ov_nxt;

  assign en_o = !ov_r || out_tready;
  assign en4  = !v4_r || en_o;
  assign en3  = !v3_r || en4;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;
  assign in_tready = en1;

  always_comb begin
    v1_nxt = en1  ? in_tvalid : v1_r;
    v2_nxt = en2  ? v1_r      : v2_r;
    v3_nxt = en3  ? v2_r      : v3_r;
    v4_nxt = en4  ? v3_r      : v4_r;
    ov_nxt = en_o ? v4_r      : ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      ov_r <= ov_nxt;
    end
  end

  // ---- stage 1: center difference, axis-axis products
  logic signed [obt_pkg::DW-1:0]               dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [obt_pkg::RPW-1:0]              pxx_r, pyy_r, pxy_r, pyx_r;
  logic signed [obt_pkg::RPW-1:0]              pxx_nxt, pyy_nxt, pxy_nxt, pyx_nxt;
  logic signed [obt_pkg::AXIS_FIELD_BITS-1:0]  arx1_r, ary1_r, brx1_r, bry1_r;
  logic [obt_pkg::SZW-1:0]                     aw1_r, ah1_r, bw1_r, bh1_r;

  always_comb begin
    dx_nxt  = {box_a.cx[obt_pkg::COORD_BITS-1], box_a.cx}
            - {box_b.cx[obt_pkg::COORD_BITS-1], box_b.cx};
    dy_nxt  = {box_a.cy[obt_pkg::COORD_BITS-1], box_a.cy}
            - {box_b.cy[obt_pkg::COORD_BITS-1], box_b.cy};
    pxx_nxt = box_a.rx * box_b.rx;
    pyy_nxt = box_a.ry * box_b.ry;
    pxy_nxt = box_a.rx * box_b.ry;
    pyx_nxt = box_a.ry * box_b.rx;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      pxx_r  <= pxx_nxt;
      pyy_r  <= pyy_nxt;
      pxy_r  <= pxy_nxt;
      pyx_r  <= pyx_nxt;
      arx1_r <= box_a.rx;
      ary1_r <= box_a.ry;
      brx1_r <= box_b.rx;
      bry1_r <= box_b.ry;
      aw1_r  <= box_a.w;
      ah1_r  <= box_a.h;
      bw1_r  <= box_b.w;
      bh1_r  <= box_b.h;
    end
  end

  // ---- stage 2: projection products, |dot| and |cross| of the right axes
  // pair i holds the two terms of axis i; the up-axis terms are subtracted
  logic signed [obt_pkg::NAX-1:0][1:0][obt_pkg::PPW-1:0] pp_r, pp_nxt;
  logic [obt_pkg::RMW-1:0]                      dotm_r, crsm_r, dotm_nxt, crsm_nxt;
  logic [obt_pkg::SZW-1:0]                      aw2_r, ah2_r, bw2_r, bh2_r;

  always_comb begin
    pp_nxt[0][0] = dx_r * arx1_r;
    pp_nxt[0][1] = dy_r * ary1_r;
    pp_nxt[1][0] = dy_r * arx1_r;
    pp_nxt[1][1] = dx_r * ary1_r;
    pp_nxt[2][0] = dx_r * brx1_r;
    pp_nxt[2][1] = dy_r * bry1_r;
    pp_nxt[3][0] = dy_r * brx1_r;
    pp_nxt[3][1] = dx_r * bry1_r;
    dotm_nxt = obt_pkg::mag_rot({pxx_r[obt_pkg::RPW-1], pxx_r}
                              + {pyy_r[obt_pkg::RPW-1], pyy_r});
    crsm_nxt = obt_pkg::mag_rot({pxy_r[obt_pkg::RPW-1], pxy_r}
                              - {pyx_r[obt_pkg::RPW-1], pyx_r});
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pp_r   <= pp_nxt;
      dotm_r <= dotm_nxt;
      crsm_r <= crsm_nxt;
      aw2_r  <= aw1_r;
      ah2_r  <= ah1_r;
      bw2_r  <= bw1_r;
      bh2_r  <= bh1_r;
    end
  end

  // ---- stage 3: projection magnitudes, other-box extent products
  logic [obt_pkg::NAX-1:0][obt_pkg::PMW-1:0]      projm_r, projm_nxt;
  logic [obt_pkg::NAX-1:0][1:0][obt_pkg::OPW-1:0] op_r, op_nxt;
  logic [obt_pkg::NAX-1:0][obt_pkg::SZW-1:0]      own3_r, own3_nxt;

  always_comb begin
    for (int i = 0; i < obt_pkg::NAX; i++) begin
      if (i == 1 || i == 3) begin
        projm_nxt[i] = obt_pkg::mag_proj({pp_r[i][0][obt_pkg::PPW-1], pp_r[i][0]}
                                       - {pp_r[i][1][obt_pkg::PPW-1], pp_r[i][1]});
      end else begin
        projm_nxt[i] = obt_pkg::mag_proj({pp_r[i][0][obt_pkg::PPW-1], pp_r[i][0]}
                                       + {pp_r[i][1][obt_pkg::PPW-1], pp_r[i][1]});
      end
    end
    op_nxt[0][0] = bh2_r * crsm_r;
    op_nxt[0][1] = bw2_r * dotm_r;
    op_nxt[1][0] = bh2_r * dotm_r;
    op_nxt[1][1] = bw2_r * crsm_r;
    op_nxt[2][0] = ah2_r * crsm_r;
    op_nxt[2][1] = aw2_r * dotm_r;
    op_nxt[3][0] = ah2_r * dotm_r;
    op_nxt[3][1] = aw2_r * crsm_r;
    own3_nxt[0]  = aw2_r;
    own3_nxt[1]  = ah2_r;
    own3_nxt[2]  = bw2_r;
    own3_nxt[3]  = bh2_r;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      projm_r <= projm_nxt;
      op_r    <= op_nxt;
      own3_r  <= own3_nxt;
    end
  end

  // ---- stage 4: scaled projection, other-box extent sum
  logic [obt_pkg::NAX-1:0][obt_pkg::LHW-1:0] lhs_r, lhs_nxt;
  logic [obt_pkg::NAX-1:0][obt_pkg::OSW-1:0] other_r, other_nxt;
  logic [obt_pkg::NAX-1:0][obt_pkg::SZW-1:0] own4_r;

  always_comb begin
    for (int i = 0; i < obt_pkg::NAX; i++) begin
      lhs_nxt[i]   = obt_pkg::LHW'(projm_r[i]) << (obt_pkg::AXIS_FRAC_BITS + 1);
      other_nxt[i] = obt_pkg::OSW'(op_r[i][0]) + obt_pkg::OSW'(op_r[i][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      lhs_r   <= lhs_nxt;
      other_r <= other_nxt;
      own4_r  <= own3_r;
    end
  end

  // ---- stage 5: compare and select into the output register
  obt_pkg::result_t res_nxt, res_r;

  obt_sep_check u_sep_check (
    .lhs   (lhs_r),
    .other (other_r),
    .own   (own4_r),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (en_o) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(obt_pkg::OUT_TDATA_W - 4){1'b0}}, res_r.axis, res_r.overlap};

  `OBT_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_tvalid, "output valid after reset")
  `OBT_ASSERT(a_accept_fills, in_tvalid && in_tready |=> v1_r, "accepted beat lost at entry")
  `OBT_ASSERT(a_flag_matches_axis, out_tvalid |-> (out_tdata[0] == (out_tdata[3:1] == obt_pkg::AXIS_NONE)), "overlap flag disagrees with axis")

endmodule

`default_nettype wire

### tb/sv/overlap_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the oriented box overlap test, predicts each result
// from the accepted input beat and compares. Depends on obt_pkg.

module overlap_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [obt_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [obt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                             mismatch_count,
  output int                             outstanding
);
  import obt_pkg::*;

  axis_t expected_axes[$];
  int    result_idx;

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    result_idx     = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t result %0d: %s", $time, result_idx, msg);
    mismatch_count++;
  endtask

  function automatic bit [63:0] abs64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // |proj| << (F+1) > other + (own << 2F), all in the common fine scale
  function automatic bit axis_splits(input longint proj, input bit [63:0] other,
                                     input bit [63:0] own);
    bit [127:0] lhs;
    bit [127:0] rhs;
    lhs = {64'd0, abs64(proj)} << (AXIS_FRAC_BITS + 1);
    rhs = ({64'd0, own} << (2 * AXIS_FRAC_BITS)) + {64'd0, other};
    return lhs > rhs;
  endfunction

  function automatic axis_t predict_overlap(input box_t a, input box_t b);
    longint    dx, dy, arx, ary, brx, bry;
    bit [63:0] aw, ah, bw, bh, dotm, crsm;
    dx   = longint'(signed'(a.cx)) - longint'(signed'(b.cx));
    dy   = longint'(signed'(a.cy)) - longint'(signed'(b.cy));
    arx  = longint'(signed'(a.rx));
    ary  = longint'(signed'(a.ry));
    brx  = longint'(signed'(b.rx));
    bry  = longint'(signed'(b.ry));
    aw   = a.w;
    ah   = a.h;
    bw   = b.w;
    bh   = b.h;
    // up axes are the right axes turned a quarter turn, so dot and cross
    // of the two right axes give every cross-box projection
    dotm = abs64(arx * brx + ary * bry);
    crsm = abs64(arx * bry - ary * brx);
    if (axis_splits(dx * arx + dy * ary, bh * crsm + bw * dotm, aw))
      return AXIS_A_RIGHT;
    if (axis_splits(dy * arx - dx * ary, bh * dotm + bw * crsm, ah))
      return AXIS_A_UP;
    if (axis_splits(dx * brx + dy * bry, ah * crsm + aw * dotm, bw))
      return AXIS_B_RIGHT;
    if (axis_splits(dy * brx - dx * bry, ah * dotm + aw * crsm, bh))
      return AXIS_B_UP;
    return AXIS_NONE;
  endfunction

  always @(posedge clk) begin
    axis_t want;
    axis_t got_axis;
    logic  got_ovl;
    box_t  a;
    box_t  b;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_ovl  = out_tdata[0];
        got_axis = axis_t'(out_tdata[3:1]);
        if (expected_axes.size() == 0) begin
          report_mismatch($sformatf("beat with nothing pending, overlap=%0b axis=%0d",
                                    got_ovl, got_axis));
        end else begin
          want = expected_axes.pop_front();
          if (got_ovl !== (want == AXIS_NONE))
            report_mismatch($sformatf("overlap got %0b want %0b", got_ovl,
                                      want == AXIS_NONE));
          if (got_axis !== want)
            report_mismatch($sformatf("separating_axis got %0d want %0d", got_axis, want));
        end
        result_idx++;
      end
      if (in_tvalid && in_tready) begin
        a = in_tdata[BOX_BITS-1:0];
        b = in_tdata[IN_BITS-1:BOX_BITS];
        expected_axes.push_back(predict_overlap(a, b));
      end
      outstanding = expected_axes.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the oriented box overlap testbench: clock, reset, stimulus and verdict.
// Depends on obt_pkg, oriented_box_overlap_test and overlap_checker.

module tb;
  import obt_pkg::*;

  localparam int RANDOM_PER_PHASE = 478;
  localparam int UNIT             = 1 << AXIS_FRAC_BITS;
  localparam int DIAG             = 11585;  // unit length / sqrt(2)
  localparam int CMAX             = (1 << (COORD_BITS - 1)) - 1;
  localparam int CMIN             = -(1 << (COORD_BITS - 1));
  localparam int SMAX             = (1 << SZW) - 1;

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  // box A then box B, each cx, cy, rx, ry, w, h from bit 0 up; zero pad on top
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // overlap, separating_axis[2:0], zero pad
  logic [OUT_TDATA_W-1:0]  out_tdata;

  int mismatch_count;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  oriented_box_overlap_test u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  overlap_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic box_t box_at(input int cx, input int cy, input int rx, input int ry,
                                  input int w, input int h);
    box_t bx;
    bx.cx = COORD_BITS'(cx);
    bx.cy = COORD_BITS'(cy);
    bx.rx = AXIS_FIELD_BITS'(rx);
    bx.ry = AXIS_FIELD_BITS'(ry);
    bx.w  = SZW'(w);
    bx.h  = SZW'(h);
    return bx;
  endfunction

  function automatic int isqrt(input int v);
    int r;
    r = 0;
    for (int step = 1 << 15; step > 0; step >>= 1)
      if ((r + step) * (r + step) <= v) r += step;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pair(input box_t a, input box_t b);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_BITS-1:0] = {b, a};
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pick_axis(output logic [AXIS_FIELD_BITS-1:0] x,
                           output logic [AXIS_FIELD_BITS-1:0] y);
    int c, s;
    if ($urandom_range(9) == 0) begin
      c = UNIT;
      s = 0;
    end else begin
      c = $urandom_range(UNIT);
      s = isqrt(UNIT * UNIT - c * c);
    end
    if ($urandom_range(1)) c = -c;
    if ($urandom_range(1)) s = -s;
    if ($urandom_range(1)) begin
      x = AXIS_FIELD_BITS'(c);
      y = AXIS_FIELD_BITS'(s);
    end else begin
      x = AXIS_FIELD_BITS'(s);
      y = AXIS_FIELD_BITS'(c);
    end
  endtask

  // mostly nearby boxes with unit axes at one of a few scales, some raw noise
  task automatic random_pair(output box_t a, output box_t b);
    int sc;
    int span;
    if ($urandom_range(99) < 12) begin
      a = box_at($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      b = box_at($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: sc = 10;
        5, 6, 7:       sc = 14;
        8:             sc = 18;
        default:       sc = 22;
      endcase
      span = 1 << sc;
      a.cx = COORD_BITS'($urandom);
      a.cy = COORD_BITS'($urandom);
      b.cx = COORD_BITS'(int'(a.cx) + int'($urandom_range(2 * span)) - span);
      b.cy = COORD_BITS'(int'(a.cy) + int'($urandom_range(2 * span)) - span);
      a.w  = SZW'($urandom_range(2 * span - 1));
      a.h  = SZW'($urandom_range(2 * span - 1));
      b.w  = SZW'($urandom_range(2 * span - 1));
      b.h  = SZW'($urandom_range(2 * span - 1));
      pick_axis(a.rx, a.ry);
      pick_axis(b.rx, b.ry);
    end
  endtask

  task automatic directed_pairs();
    box_t a0;
    a0 = box_at(0, 0, UNIT, 0, 512, 512);
    send_pair(a0, a0);                                           // identical
    send_pair(a0, box_at(2048, 0, UNIT, 0, 512, 512));           // split on A right
    send_pair(a0, box_at(0, 2048, UNIT, 0, 512, 512));           // split on A up
    send_pair(a0, box_at(563, 563, DIAG, DIAG, 512, 512));       // split on B right
    send_pair(a0, box_at(563, 563, DIAG, -DIAG, 512, 512));      // split on B up
    send_pair(a0, box_at(512, 0, UNIT, 0, 512, 512));            // exactly touching
    send_pair(a0, box_at(513, 0, UNIT, 0, 512, 512));            // one lsb apart
    send_pair(box_at(0, 0, UNIT, 0, 0, 0), box_at(0, 0, 0, UNIT, 0, 0));
    send_pair(box_at(1, 0, UNIT, 0, 0, 0), box_at(0, 0, UNIT, 0, 0, 0));
    send_pair(box_at(CMAX, CMAX, UNIT, 0, SMAX, SMAX),
              box_at(CMIN, CMIN, 0, UNIT, SMAX, SMAX));
    send_pair(box_at(CMAX, CMIN, -UNIT, 0, 0, 0),
              box_at(CMIN, CMAX, 0, -UNIT, 0, 0));
    send_pair(box_at(CMIN, CMIN, -32768, -32768, SMAX, SMAX),
              box_at(CMAX, CMAX, 32767, -32768, SMAX, SMAX));
    send_pair(box_at(100, -300, 0, 0, 1000, 1000), box_at(-5000, 7000, 0, 0, 3, 3));
    send_pair(box_at(0, 0, 5, 3, 2000, 100), box_at(900, 40, -3, 7, 50, 700));
    send_pair(box_at(-1, -1, -1, -1, -1, -1), box_at(-1, -1, -1, -1, -1, -1));
    send_pair(box_at(0, 0, 0, 0, 0, 0), box_at(0, 0, 0, 0, 0, 0));
    send_pair(box_at(-700, 300, 0, -UNIT, SMAX, 1), box_at(700, -300, -DIAG, DIAG, 1, SMAX));
    send_pair(box_at(0, 0, UNIT, UNIT, 256, 256), box_at(0, 0, -UNIT, UNIT, 256, 256));
  endtask

  initial begin
    box_t a, b;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 9;  rx_idle_pct = 81; end
        1:       begin tx_idle_pct = 81; rx_idle_pct = 9;  end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      if (ph == 0) directed_pairs();
      repeat (RANDOM_PER_PHASE) begin
        random_pair(a, b);
        send_pair(a, b);
      end
      // hold off until the pipeline has drained before the next phase
      in_tvalid <= 1'b0;
      do @(negedge clk); while (outstanding != 0);
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
